@@ hdl/binary_min_heap_queue_top_macros.svh @@
// assertion macros for the heap queue top level
// expects clk and rst_n in the scope of each use
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH

// condition must never hold outside reset
`define BMHQ_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BMHQ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/bmhq_pkg.sv @@
// shared constants for the binary min-heap priority queue
// no dependencies
package bmhq_pkg;

    localparam int BMHQ_CAPACITY  = 1024;
    localparam int BMHQ_KEY_BITS  = 16;
    localparam int BMHQ_KEY_PORT  = 16;
    localparam int BMHQ_SYM_BITS  = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

@@ hdl/bmhq_ram.sv @@
// heap entry storage: one write port, two read ports, registered read data
// no dependencies
module bmhq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ hdl/binary_min_heap_queue_top.sv @@
// Binary min-heap priority queue of (key, symbol) entries: insert and pop-minimum.
// Accepts a word when start is high and busy is low. One result word per accepted
// word, shown for one cycle with done high; the receiver cannot stall it.
// An insert into a non-empty heap moves the parent down for each level the
// entry rises, then writes the entry; a pop reads the root and the last entry,
// then moves the smaller child up for each level the moved entry sinks, or writes
// the last entry to the root when at most one entry is left. Done is registered
// from the last step and the next word can be taken in the cycle that done is high.
// Each heap level costs one read, compare and write-back of the entry store. Refused
// words and an insert into an empty heap finish without busy going high. The store
// needs no clearing after reset. Depends on bmhq_pkg, bmhq_ram and the macro header.
`include "binary_min_heap_queue_top_macros.svh"

module binary_min_heap_queue_top
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = BMHQ_CAPACITY,
    parameter int KEY_BITS = BMHQ_KEY_BITS,
    localparam int PW = $clog2(CAPACITY + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     opcode,
    input  logic [BMHQ_KEY_PORT-1:0] in_key,
    input  logic [BMHQ_SYM_BITS-1:0] in_symbol,
    output logic                     done,
    output logic [BMHQ_KEY_PORT-1:0] out_key,
    output logic [BMHQ_SYM_BITS-1:0] out_symbol,
    output logic                     out_valid,
    output logic [1:0]               status,
    output logic [PW-1:0]            entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int SK = (KEY_BITS < BMHQ_KEY_PORT) ? KEY_BITS : BMHQ_KEY_PORT;
    localparam int EW = SK + BMHQ_SYM_BITS;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    typedef struct packed {
        logic [SK-1:0]            key;
        logic [BMHQ_SYM_BITS-1:0] sym;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_UP    = 5'b00010,
        S_POP   = 5'b00100,
        S_DOWN  = 5'b01000,
        S_PLACE = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [PW-1:0]            count_reg, count_next;
    logic [PW-1:0]            hole_reg, hole_next;
    entry_t                   entry_reg, entry_next;
    logic [BMHQ_KEY_PORT-1:0] out_key_reg, out_key_next;
    logic [BMHQ_SYM_BITS-1:0] out_symbol_reg, out_symbol_next;
    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               status_reg, status_next;
    logic                     done_reg, done_next;

    logic          we;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    entry_t        wdata, rd_a, rd_b;

    // heap position (1-based) to store address
    function automatic logic [AW-1:0] p2a(input logic [PW:0] p);
        logic [PW:0] t;
        t = p - 1'b1;
        return t[AW-1:0];
    endfunction

    bmhq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    logic [PW:0] new_hole, left_pos, next_left;
    logic [PW:0] child_pos;
    logic        right_ok, pick_right, has_child;
    entry_t      child;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        hole_next       = hole_reg;
        entry_next      = entry_reg;
        out_key_next    = out_key_reg;
        out_symbol_next = out_symbol_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        done_next       = 1'b0;
        we              = 1'b0;
        waddr           = '0;
        wdata           = entry_reg;
        raddr_a         = '0;
        raddr_b         = '0;

        new_hole   = {1'b0, count_reg} + 1'b1;
        left_pos   = {hole_reg, 1'b0};
        has_child  = left_pos <= {1'b0, count_reg};
        right_ok   = left_pos < {1'b0, count_reg};
        pick_right = right_ok && (rd_a.key > rd_b.key);
        child      = pick_right ? rd_b : rd_a;
        child_pos  = pick_right ? (left_pos + 1'b1) : left_pos;
        next_left  = {child_pos[PW-1:0], 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    out_key_next    = '0;
                    out_symbol_next = '0;
                    out_valid_next  = 1'b0;
                    status_next     = ST_OK;
                    case (opcode)
                        OP_INSERT:
                        begin
                            if (count_reg == CAP_P)
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                count_next     = new_hole[PW-1:0];
                                hole_next      = new_hole[PW-1:0];
                                entry_next.key = in_key[SK-1:0];
                                entry_next.sym = in_symbol;
                                if (count_reg == '0)
                                begin
                                    we        = 1'b1;
                                    waddr     = '0;
                                    wdata     = entry_next;
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    raddr_a    = p2a(new_hole >> 1);
                                    state_next = S_UP;
                                end
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                raddr_a    = '0;
                                raddr_b    = p2a({1'b0, count_reg});
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                if (rd_a.key > entry_reg.key)
                begin
                    // parent moves down into the hole
                    we        = 1'b1;
                    waddr     = p2a({1'b0, hole_reg});
                    wdata     = rd_a;
                    hole_next = hole_reg >> 1;
                    if ((hole_reg >> 1) == PW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        raddr_a = p2a({1'b0, hole_reg >> 2});
                    end
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = p2a({1'b0, hole_reg});
                    wdata      = entry_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                out_key_next    = BMHQ_KEY_PORT'(rd_a.key);
                out_symbol_next = rd_a.sym;
                out_valid_next  = 1'b1;
                entry_next      = rd_b;
                hole_next       = PW'(1);
                if (count_reg < PW'(2))
                begin
                    we         = 1'b1;
                    waddr      = '0;
                    wdata      = rd_b;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    raddr_a    = p2a((PW + 1)'(2));
                    raddr_b    = p2a((PW + 1)'(3));
                    state_next = S_DOWN;
                end
            end
            S_DOWN:
            begin
                if (entry_reg.key > child.key)
                begin
                    // smaller child moves up into the hole
                    we        = 1'b1;
                    waddr     = p2a({1'b0, hole_reg});
                    wdata     = child;
                    hole_next = child_pos[PW-1:0];
                    if (next_left > {1'b0, count_reg})
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        raddr_a = p2a(next_left);
                        raddr_b = next_left[AW-1:0];
                    end
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = p2a({1'b0, hole_reg});
                    wdata      = entry_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PLACE:
            begin
                we         = 1'b1;
                waddr      = p2a({1'b0, hole_reg});
                wdata      = entry_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg       <= hole_next;
        entry_reg      <= entry_next;
        out_key_reg    <= out_key_next;
        out_symbol_reg <= out_symbol_next;
        out_valid_reg  <= out_valid_next;
        status_reg     <= status_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign out_key     = out_key_reg;
    assign out_symbol  = out_symbol_reg;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;

    `BMHQ_ASSERT_NEVER(a_count_bound, count_reg > CAP_P, "fill count above capacity")
    `BMHQ_ASSERT_IMPLY(a_up_has_parent, state_reg == S_UP, hole_reg > PW'(1), "hole at root")
    `BMHQ_ASSERT_IMPLY(a_down_has_child, state_reg == S_DOWN, has_child, "hole has no child")
    `BMHQ_ASSERT_IMPLY(a_valid_ok, done && out_valid, status == ST_OK, "pop with error status")

endmodule

@@ bench/tb_top.sv @@
// testbench for binary_min_heap_queue_top: directed, fill-to-capacity and random traffic
// predicts every result word with a local heap mirror and checks each done strobe
// depends on bmhq_pkg and the rtl of binary_min_heap_queue_top
module tb_top
    import bmhq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_W        = $clog2(BMHQ_CAPACITY + 1);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [BMHQ_KEY_PORT-1:0] KEY_MASK =
        BMHQ_KEY_PORT'((64'd1 << BMHQ_KEY_BITS) - 64'd1);

    typedef struct packed {
        logic [BMHQ_KEY_PORT-1:0] key;
        logic [BMHQ_SYM_BITS-1:0] symbol;
        logic                     valid;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
    } heap_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     opcode;
    logic [BMHQ_KEY_PORT-1:0] in_key;
    logic [BMHQ_SYM_BITS-1:0] in_symbol;
    logic                     done;
    logic [BMHQ_KEY_PORT-1:0] out_key;
    logic [BMHQ_SYM_BITS-1:0] out_symbol;
    logic                     out_valid;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       entry_count;

    // heap mirror, slot 1 is the root
    logic [BMHQ_KEY_PORT-1:0] mirror_key [1:BMHQ_CAPACITY];
    logic [BMHQ_SYM_BITS-1:0] mirror_sym [1:BMHQ_CAPACITY];
    int                       mirror_count;

    heap_result_t pending_results[$];
    int           mismatch_count = 0;
    int           sender_idle_pct = 0;
    int           idle_cycles = 0;

    binary_min_heap_queue_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .in_key      (in_key),
        .in_symbol   (in_symbol),
        .done        (done),
        .out_key     (out_key),
        .out_symbol  (out_symbol),
        .out_valid   (out_valid),
        .status      (status),
        .entry_count (entry_count)
    );

    always #6 clk = ~clk;

    function automatic void mirror_swap(input int a, input int b);
        logic [BMHQ_KEY_PORT-1:0] tk;
        logic [BMHQ_SYM_BITS-1:0] ts;
        tk = mirror_key[a];
        ts = mirror_sym[a];
        mirror_key[a] = mirror_key[b];
        mirror_sym[a] = mirror_sym[b];
        mirror_key[b] = tk;
        mirror_sym[b] = ts;
    endfunction

    function automatic heap_result_t predict_heap_op(input logic op,
                                                     input logic [BMHQ_KEY_PORT-1:0] key,
                                                     input logic [BMHQ_SYM_BITS-1:0] sym);
        heap_result_t r;
        int           pos;
        int           child;
        logic         sinking;
        r = '0;
        if (op == OP_INSERT)
        begin
            if (mirror_count >= BMHQ_CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                mirror_count++;
                mirror_key[mirror_count] = key & KEY_MASK;
                mirror_sym[mirror_count] = sym;
                pos = mirror_count;
                // rise only while the parent is strictly larger
                while (pos > 1 && mirror_key[pos / 2] > mirror_key[pos])
                begin
                    mirror_swap(pos, pos / 2);
                    pos = pos / 2;
                end
            end
        end
        else
        begin
            if (mirror_count == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.key    = mirror_key[1];
                r.symbol = mirror_sym[1];
                r.valid  = 1'b1;
                mirror_key[1] = mirror_key[mirror_count];
                mirror_sym[1] = mirror_sym[mirror_count];
                mirror_count--;
                pos = 1;
                sinking = 1'b1;
                // left child wins a tie, stop unless strictly larger than the child
                while (sinking && 2 * pos <= mirror_count)
                begin
                    child = 2 * pos;
                    if (child < mirror_count && mirror_key[child] > mirror_key[child + 1])
                        child++;
                    if (mirror_key[pos] > mirror_key[child])
                    begin
                        mirror_swap(pos, child);
                        pos = child;
                    end
                    else
                    begin
                        sinking = 1'b0;
                    end
                end
            end
        end
        r.count = COUNT_W'(mirror_count);
        return r;
    endfunction

    function automatic logic [BMHQ_KEY_PORT-1:0] pick_key();
        int sel;
        sel = $urandom_range(9);
        if (sel < 3)
            return BMHQ_KEY_PORT'($urandom);
        else if (sel < 7)
            return BMHQ_KEY_PORT'($urandom_range(15));
        else if (sel < 8)
            return {BMHQ_KEY_PORT{1'b1}} - BMHQ_KEY_PORT'($urandom_range(3));
        else
            return BMHQ_KEY_PORT'($urandom_range(300, 260));
    endfunction

    // called at a rising edge; returns at the edge that accepts the word, or after a random idle pause with start low
    task automatic send_word(input logic op, input logic [BMHQ_KEY_PORT-1:0] key,
                             input logic [BMHQ_SYM_BITS-1:0] sym);
        start     <= 1'b1;
        opcode    <= op;
        in_key    <= key;
        in_symbol <= sym;
        do @(posedge clk); while (busy);
        pending_results.push_back(predict_heap_op(op, key, sym));
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed_corners();
        sender_idle_pct = 0;
        send_word(OP_POP, 16'hFFFF, 8'hFF);
        send_word(OP_INSERT, 16'hFFFF, 8'hFF);
        send_word(OP_INSERT, 16'h0000, 8'h00);
        send_word(OP_INSERT, 16'h8000, 8'h5A);
        send_word(OP_INSERT, 16'h8000, 8'hA5);
        send_word(OP_INSERT, 16'h8000, 8'h3C);
        send_word(OP_INSERT, 16'h0001, 8'h80);
        send_word(OP_INSERT, 16'h7FFF, 8'h01);
        repeat (8) send_word(OP_POP, 16'h0000, 8'h00);
        wait_until_drained();
        // all keys equal: no swaps on either sift path
        for (int i = 0; i < 5; i++)
            send_word(OP_INSERT, 16'h1234, BMHQ_SYM_BITS'(8'hC0 + i));
        repeat (5) send_word(OP_POP, 16'h5555, 8'hAA);
        wait_until_drained();
    endtask

    // fills the heap, checks the full refusal and leaves it full
    task automatic test_fill_to_capacity();
        sender_idle_pct = 0;
        while (mirror_count < BMHQ_CAPACITY)
            send_word(OP_INSERT, pick_key(), BMHQ_SYM_BITS'($urandom));
        send_word(OP_INSERT, pick_key(), BMHQ_SYM_BITS'($urandom));
        send_word(OP_POP, pick_key(), BMHQ_SYM_BITS'($urandom));
        send_word(OP_INSERT, pick_key(), BMHQ_SYM_BITS'($urandom));
        send_word(OP_INSERT, pick_key(), BMHQ_SYM_BITS'($urandom));
        wait_until_drained();
    endtask

    task automatic test_random_traffic(input int words, input int idle_pct);
        int insert_pct;
        logic op;
        sender_idle_pct = idle_pct;
        for (int i = 0; i < words; i++)
        begin
            if (mirror_count < 8)
                insert_pct = 70;
            else if (mirror_count > 300)
                insert_pct = 35;
            else
                insert_pct = 52;
            op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP;
            send_word(op, pick_key(), BMHQ_SYM_BITS'($urandom));
            if ($urandom_range(59) == 0)
                wait_until_drained();
        end
        wait_until_drained();
    endtask

    always @(posedge clk)
    begin : check_results
        heap_result_t got;
        heap_result_t want;
        if (rst_n && done)
        begin
            got.key    = out_key;
            got.symbol = out_symbol;
            got.valid  = out_valid;
            got.status = status;
            got.count  = entry_count;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected word key %h sym %h valid %b status %0d count %0d",
                             $realtime, got.key, got.symbol, got.valid, got.status,
                             got.count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.key !== want.key || got.symbol !== want.symbol ||
                    got.valid !== want.valid || got.status !== want.status ||
                    got.count !== want.count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: mismatch exp key %h sym %h valid %b status %0d count %0d",
                                 $realtime, want.key, want.symbol, want.valid, want.status,
                                 want.count);
                        $display("    got key %h sym %h valid %b status %0d count %0d",
                                 got.key, got.symbol, got.valid, got.status, got.count);
                    end
                end
            end
        end
    end

    // cycles with neither a word accepted nor a result seen
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        opcode       <= OP_INSERT;
        in_key       <= '0;
        in_symbol    <= '0;
        mirror_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_fill_to_capacity();
        test_random_traffic(40, 0);
        test_random_traffic(40, 70);
        test_random_traffic(40, 0);
        test_random_traffic(40, 33);

        wait_until_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/bmhq_pkg.sv
hdl/bmhq_ram.sv
hdl/binary_min_heap_queue_top.sv
bench/tb_top.sv
